// ----- src/swsr_pkg.sv -----
// Package with shared constants and controller/datapath types for the sliding window block.
package swsr_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int IDX_BITS    = 10;
    localparam int MAX_SERIES  = 1024;
    localparam int SUM_BITS    = 29;
    localparam int SQ_BITS     = 44;
    localparam int WIN_BITS    = 13;
    localparam int NS_BITS     = 11;
    localparam int MAX_WINDOW  = 4096;
    localparam int MANT_BITS   = 16;
    localparam int EXP_BITS    = 5;
    localparam int EXP_MAX     = 27;
    localparam int D_BITS      = 58;
    localparam int ROOT_BITS   = 92;
    localparam int ADDR_BITS   = 3;
    localparam int DATA_BITS   = 32;

    localparam logic [0:0] REG_WINDOW = 1'b0;
    localparam logic [0:0] REG_SERIES = 1'b1;

    typedef struct packed {
        logic load_in;
        logic rd;
        logic upd;
        logic mul_lo;
        logic mul_hi;
        logic mul_ss;
        logic diff;
        logic exp_step;
        logic root_init;
        logic root_step;
        logic out_load;
    } swsr_cmd_t;

    typedef struct packed {
        logic range_err;
        logic zero_d;
        logic exp_done;
        logic out_free;
    } swsr_sts_t;

endpackage

// ----- src/swsr_if.sv -----
// Channel interfaces for input samples and result transactions.
interface swsr_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [swsr_pkg::IDX_BITS-1:0]        series_index;
    logic                                 first_step;
    logic signed [swsr_pkg::SAMPLE_BITS-1:0] new_sample;
    logic signed [swsr_pkg::SAMPLE_BITS-1:0] old_sample;

    modport source (output valid, series_index, first_step, new_sample, old_sample,
                    input ready);
    modport sink (input valid, series_index, first_step, new_sample, old_sample,
                  output ready);
endinterface

interface swsr_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [swsr_pkg::IDX_BITS-1:0]        series_out;
    logic signed [swsr_pkg::SUM_BITS-1:0] window_sum;
    logic [swsr_pkg::MANT_BITS-1:0]       inv_mantissa;
    logic [swsr_pkg::EXP_BITS-1:0]        inv_exponent;
    logic                                 zero_variance;
    logic                                 range_error;
    logic signed [swsr_pkg::SAMPLE_BITS-1:0] new_out;
    logic signed [swsr_pkg::SAMPLE_BITS-1:0] old_out;

    modport source (output valid, series_out, window_sum, inv_mantissa, inv_exponent,
                    zero_variance, range_error, new_out, old_out, input ready);
    modport sink (input valid, series_out, window_sum, inv_mantissa, inv_exponent,
                  zero_variance, range_error, new_out, old_out, output ready);
endinterface

// ----- src/sliding_window_sum_rsqrt.sv -----
// Top level of the sliding window sum and reciprocal square root block.
// Each input transaction carries one sample of one of up to 1024 interleaved series;
// the block updates that series' window sum and sum of squares in on-chip stores, forms
// window_size*sumsq - sum^2 and returns the sum with its reciprocal square root as a
// mantissa and exponent. One sample is processed at a time: a valid series passes through
// the exponent search (one step per cycle, up to 27) and the 16-step bit-serial square
// root, a zero variance term skips both, and an out-of-range series goes from the read
// straight to the result. The finished result sits in an output register, so the next
// sample is accepted in the cycle after it is loaded, while it waits. The sum stores
// hold undefined data after reset until a series has been started with first_step.
module sliding_window_sum_rsqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [swsr_pkg::ADDR_BITS-1:0] paddr,
    input  logic [swsr_pkg::DATA_BITS-1:0] pwdata,
    output logic [swsr_pkg::DATA_BITS-1:0] prdata,
    output logic                           pready,
    swsr_in_if.sink                        in_ch,
    swsr_out_if.source                     out_ch
);
    logic [swsr_pkg::WIN_BITS-1:0] window_size;
    logic [swsr_pkg::NS_BITS-1:0]  num_series;
    swsr_pkg::swsr_cmd_t           cmd;
    swsr_pkg::swsr_sts_t           sts;

    swsr_cfg u_cfg (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .window_size (window_size),
        .num_series  (num_series)
    );

    swsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swsr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .window_size (window_size),
        .num_series  (num_series),
        .in_ch       (in_ch),
        .out_ch      (out_ch)
    );
endmodule

// ----- src/swsr_cfg.sv -----
// APB-style configuration registers for window size and series count.
module swsr_cfg (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swsr_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [swsr_pkg::DATA_BITS-1:0]    pwdata,
    output logic [swsr_pkg::DATA_BITS-1:0]    prdata,
    output logic                              pready,
    output logic [swsr_pkg::WIN_BITS-1:0]     window_size,
    output logic [swsr_pkg::NS_BITS-1:0]      num_series
);
    logic [swsr_pkg::WIN_BITS-1:0] win_reg;
    logic [swsr_pkg::NS_BITS-1:0]  ns_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= swsr_pkg::WIN_BITS'(2);
            ns_reg  <= swsr_pkg::NS_BITS'(1);
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                swsr_pkg::REG_WINDOW: win_reg <= pwdata[swsr_pkg::WIN_BITS-1:0];
                swsr_pkg::REG_SERIES: ns_reg  <= pwdata[swsr_pkg::NS_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            swsr_pkg::REG_WINDOW: prdata = swsr_pkg::DATA_BITS'(win_reg);
            swsr_pkg::REG_SERIES: prdata = swsr_pkg::DATA_BITS'(ns_reg);
            default:              prdata = '0;
        endcase
    end

    assign window_size = win_reg;
    assign num_series  = ns_reg;
endmodule

// ----- src/swsr_ctrl.sv -----
// Controller state machine that sequences one sample through the datapath.
module swsr_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  swsr_pkg::swsr_sts_t sts,
    output swsr_pkg::swsr_cmd_t cmd
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_UPD  = 4'd2;
    localparam logic [3:0] S_MUL0 = 4'd3;
    localparam logic [3:0] S_MUL1 = 4'd4;
    localparam logic [3:0] S_MUL2 = 4'd5;
    localparam logic [3:0] S_DIFF = 4'd6;
    localparam logic [3:0] S_EXP  = 4'd7;
    localparam logic [3:0] S_ROOT = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0] state_reg, state_next;
    logic [3:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_READ;
                end
            end
            S_READ:
            begin
                cmd.rd     = 1'b1;
                state_next = sts.range_err ? S_DONE : S_UPD;
            end
            S_UPD:
            begin
                cmd.upd    = 1'b1;
                state_next = S_MUL0;
            end
            S_MUL0:
            begin
                cmd.mul_lo = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_hi = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_ss = 1'b1;
                state_next = S_DIFF;
            end
            S_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = S_EXP;
            end
            S_EXP:
            begin
                if (sts.zero_d)
                begin
                    state_next = S_DONE;
                end
                else if (sts.exp_done)
                begin
                    cmd.root_init = 1'b1;
                    cnt_next      = 4'd15;
                    state_next    = S_ROOT;
                end
                else
                begin
                    cmd.exp_step = 1'b1;
                end
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (cnt_reg == 4'd0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 4'd1;
                end
            end
            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |-> (state_reg == S_IDLE))
        else $error("input taken outside idle");
    a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending transaction");
    a_root_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT && cnt_reg == 4'd0) |=> (state_reg == S_DONE))
        else $error("root iteration did not finish");
endmodule

// ----- src/swsr_dp.sv -----
// Datapath with per-series sum stores, variance term and reciprocal square root.
module swsr_dp (
    input  logic                clk,
    input  logic                rst_n,
    input  swsr_pkg::swsr_cmd_t cmd,
    output swsr_pkg::swsr_sts_t sts,
    input  logic [swsr_pkg::WIN_BITS-1:0] window_size,
    input  logic [swsr_pkg::NS_BITS-1:0]  num_series,
    swsr_in_if.sink                       in_ch,
    swsr_out_if.source                    out_ch
);
    localparam int SB = swsr_pkg::SAMPLE_BITS;
    localparam int RB = swsr_pkg::ROOT_BITS;
    localparam int DB = swsr_pkg::D_BITS;

    logic [swsr_pkg::SUM_BITS-1:0] sum_mem [swsr_pkg::MAX_SERIES];
    logic [swsr_pkg::SQ_BITS-1:0]  sq_mem  [swsr_pkg::MAX_SERIES];

    logic [swsr_pkg::IDX_BITS-1:0] idx_reg;
    logic                          first_reg;
    logic signed [SB-1:0]          new_reg, old_reg;
    logic [swsr_pkg::SUM_BITS-1:0] rd_sum_reg;
    logic [swsr_pkg::SQ_BITS-1:0]  rd_sq_reg;
    logic signed [2*SB-1:0]        nn_reg, oo_reg;
    logic signed [swsr_pkg::SUM_BITS-1:0] s_reg, s_next;
    logic signed [swsr_pkg::SQ_BITS-1:0]  q_reg, q_next;
    logic [swsr_pkg::WIN_BITS-1:0] w_eff;
    logic [34:0]                   plo_reg;
    logic signed [35:0]            phi_reg;
    logic signed [57:0]            ss_reg;
    logic signed [58:0]            wq, d_full;
    logic [DB-1:0]                 d_reg, t_reg;
    logic                          zero_reg;
    logic [swsr_pkg::EXP_BITS-1:0] e_reg;
    logic                          exp_go;
    logic [RB-1:0]                 p_reg, rs_reg, ds_reg, thr_reg, cand;
    logic                          take;
    logic [swsr_pkg::MANT_BITS-1:0] m_reg, mant;
    logic                          range_err;
    logic                          out_valid_reg, out_valid_next;
    logic [swsr_pkg::IDX_BITS-1:0] o_idx_reg;
    logic signed [swsr_pkg::SUM_BITS-1:0] o_sum_reg;
    logic [swsr_pkg::MANT_BITS-1:0] o_mant_reg;
    logic [swsr_pkg::EXP_BITS-1:0] o_exp_reg;
    logic                          o_zero_reg, o_rerr_reg;
    logic signed [SB-1:0]          o_new_reg, o_old_reg;

    assign range_err = ({1'b0, idx_reg} >= num_series);
    assign w_eff = (window_size > swsr_pkg::WIN_BITS'(swsr_pkg::MAX_WINDOW))
                 ? swsr_pkg::WIN_BITS'(swsr_pkg::MAX_WINDOW) : window_size;

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_sum_reg <= sum_mem[idx_reg];
            rd_sq_reg  <= sq_mem[idx_reg];
        end
        if (cmd.upd)
        begin
            sum_mem[idx_reg] <= s_next;
            sq_mem[idx_reg]  <= q_next;
        end
    end

    always_comb
    begin
        if (first_reg)
        begin
            s_next = swsr_pkg::SUM_BITS'(new_reg);
            q_next = swsr_pkg::SQ_BITS'(nn_reg);
        end
        else
        begin
            s_next = $signed(rd_sum_reg) + swsr_pkg::SUM_BITS'(new_reg)
                   - swsr_pkg::SUM_BITS'(old_reg);
            q_next = $signed(rd_sq_reg) + swsr_pkg::SQ_BITS'(nn_reg)
                   - swsr_pkg::SQ_BITS'(oo_reg);
        end
    end

    assign wq     = (59'(phi_reg) <<< 22) + $signed(59'(plo_reg));
    assign d_full = wq - 59'(ss_reg);
    assign exp_go = (|t_reg[DB-1:2]) && (e_reg < swsr_pkg::EXP_BITS'(swsr_pkg::EXP_MAX));
    assign cand   = p_reg + rs_reg + ds_reg;
    assign take   = (cand <= thr_reg);
    assign mant   = (m_reg > 16'h8000) ? 16'h8000 : m_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            idx_reg   <= in_ch.series_index;
            first_reg <= in_ch.first_step;
            new_reg   <= in_ch.new_sample;
            old_reg   <= in_ch.old_sample;
        end
        if (cmd.rd)
        begin
            nn_reg <= new_reg * new_reg;
            oo_reg <= old_reg * old_reg;
        end
        if (cmd.upd)
        begin
            s_reg <= s_next;
            q_reg <= q_next;
        end
        if (cmd.mul_lo)
        begin
            plo_reg <= 35'(w_eff) * 35'(q_reg[21:0]);
        end
        if (cmd.mul_hi)
        begin
            phi_reg <= 36'($signed({1'b0, w_eff})) * 36'($signed(q_reg[43:22]));
        end
        if (cmd.mul_ss)
        begin
            ss_reg <= 58'(s_reg) * 58'(s_reg);
        end
        if (cmd.diff)
        begin
            zero_reg <= d_full[58] || (d_full == '0);
            d_reg    <= d_full[DB-1:0];
            t_reg    <= d_full[DB-1:0];
            e_reg    <= '0;
        end
        if (cmd.exp_step)
        begin
            t_reg <= t_reg >> 2;
            e_reg <= e_reg + swsr_pkg::EXP_BITS'(1);
        end
        if (cmd.root_init)
        begin
            p_reg   <= '0;
            rs_reg  <= '0;
            ds_reg  <= RB'(d_reg) << 30;
            thr_reg <= RB'(1) << (7'd30 + 7'({e_reg, 1'b0}));
            m_reg   <= '0;
        end
        if (cmd.root_step)
        begin
            m_reg  <= {m_reg[swsr_pkg::MANT_BITS-2:0], take};
            ds_reg <= ds_reg >> 2;
            if (take)
            begin
                p_reg  <= cand;
                rs_reg <= (rs_reg >> 1) + ds_reg;
            end
            else
            begin
                rs_reg <= rs_reg >> 1;
            end
        end
        if (cmd.out_load)
        begin
            o_idx_reg  <= idx_reg;
            o_new_reg  <= new_reg;
            o_old_reg  <= old_reg;
            o_rerr_reg <= range_err;
            if (range_err)
            begin
                o_sum_reg  <= '0;
                o_mant_reg <= '0;
                o_exp_reg  <= '0;
                o_zero_reg <= 1'b0;
            end
            else
            begin
                o_sum_reg  <= s_reg;
                o_zero_reg <= zero_reg;
                o_mant_reg <= zero_reg ? '0 : mant;
                o_exp_reg  <= zero_reg ? '0 : e_reg;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.range_err = range_err;
    assign sts.zero_d    = zero_reg;
    assign sts.exp_done  = !exp_go;
    assign sts.out_free  = !out_valid_reg || out_ch.ready;

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.series_out    = o_idx_reg;
    assign out_ch.window_sum    = o_sum_reg;
    assign out_ch.inv_mantissa  = o_mant_reg;
    assign out_ch.inv_exponent  = o_exp_reg;
    assign out_ch.zero_variance = o_zero_reg;
    assign out_ch.range_error   = o_rerr_reg;
    assign out_ch.new_out       = o_new_reg;
    assign out_ch.old_out       = o_old_reg;
endmodule
